// ----- hw/rtl/char_to_bits_prefix_code_decoder_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Char-to-bits prefix decoder: assertion macros
// Concurrent checks on clock with synchronous reset; empty under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef CHAR_TO_BITS_PREFIX_CODE_DECODER_UNIT_DEFINES_SVH
`define CHAR_TO_BITS_PREFIX_CODE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define C2B_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);
// next-cycle implication
`define C2B_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`else
`define C2B_ASSERT_IMP(label, cond, prop, msg)
`define C2B_ASSERT_NXT(label, cond, prop, msg)
`endif

`endif

// ----- hw/rtl/c2b_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2b_pkg
// Types, symbol mapping and codeword table of the char-to-bits decoder.
// ---------------------------------------------------------------------------
package c2b_pkg;

   localparam int QUEUE_DEPTH = 4;

   // 5-bit symbol codes of the punctuation characters (letters take 0..25)
   localparam logic [4:0] SYM_SPACE  = 5'd26;
   localparam logic [4:0] SYM_PERIOD = 5'd27;
   localparam logic [4:0] SYM_COMMA  = 5'd28;
   localparam logic [4:0] SYM_HYPHEN = 5'd29;
   localparam logic [4:0] SYM_APOS   = 5'd30;
   localparam logic [4:0] SYM_QMARK  = 5'd31;

   localparam logic [7:0] CHR_A      = 8'h41;
   localparam logic [7:0] CHR_Z      = 8'h5A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_PERIOD = 8'h2E;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;
   localparam logic [7:0] CHR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHR_APOS   = 8'h27;
   localparam logic [7:0] CHR_QMARK  = 8'h3F;

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } sym_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       out_valid;
      logic       out_line_end;
   } rsp_type;

   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic sym_type symbol_of(input logic [7:0] c);
      sym_type s;
      s.hit  = 1'b1;
      s.code = '0;
      unique case (c) inside
         [CHR_A:CHR_Z]: s.code = 5'(c - CHR_A);
         CHR_SPACE:     s.code = SYM_SPACE;
         CHR_PERIOD:    s.code = SYM_PERIOD;
         CHR_COMMA:     s.code = SYM_COMMA;
         CHR_HYPHEN:    s.code = SYM_HYPHEN;
         CHR_APOS:      s.code = SYM_APOS;
         CHR_QMARK:     s.code = SYM_QMARK;
         default:       s.hit  = 1'b0;
      endcase
      return s;
   endfunction

   // Codeword of the given length -> ASCII; zero when nothing matches.
   function automatic logic [6:0] lookup(input logic [3:0] len, input logic [7:0] code);
      logic [6:0] ch;
      unique case ({len, code})
         {4'd3, 8'h05}: ch = 7'h20;
         {4'd6, 8'h00}: ch = 7'h27;
         {4'd6, 8'h03}: ch = 7'h2C;
         {4'd8, 8'h91}: ch = 7'h2D;
         {4'd6, 8'h11}: ch = 7'h2E;
         {4'd6, 8'h01}: ch = 7'h3F;
         {4'd6, 8'h25}: ch = 7'h41;
         {4'd8, 8'h9A}: ch = 7'h42;
         {4'd4, 8'h05}: ch = 7'h43;
         {4'd4, 8'h01}: ch = 7'h44;
         {4'd3, 8'h06}: ch = 7'h45;
         {4'd5, 8'h09}: ch = 7'h46;
         {4'd8, 8'h9B}: ch = 7'h47;
         {4'd6, 8'h10}: ch = 7'h48;
         {4'd4, 8'h07}: ch = 7'h49;
         {4'd8, 8'h98}: ch = 7'h4A;
         {4'd4, 8'h06}: ch = 7'h4B;
         {4'd5, 8'h04}: ch = 7'h4C;
         {4'd8, 8'h99}: ch = 7'h4D;
         {4'd8, 8'h9E}: ch = 7'h4E;
         {4'd5, 8'h05}: ch = 7'h4F;
         {4'd3, 8'h07}: ch = 7'h50;
         {4'd8, 8'h9F}: ch = 7'h51;
         {4'd4, 8'h08}: ch = 7'h52;
         {4'd5, 8'h06}: ch = 7'h53;
         {4'd5, 8'h07}: ch = 7'h54;
         {4'd8, 8'h9C}: ch = 7'h55;
         {4'd8, 8'h9D}: ch = 7'h56;
         {4'd6, 8'h02}: ch = 7'h57;
         {4'd8, 8'h92}: ch = 7'h58;
         {4'd8, 8'h93}: ch = 7'h59;
         {4'd8, 8'h90}: ch = 7'h5A;
         default:       ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- hw/rtl/c2b_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2b_front
// Maps a character to its 5-bit symbol, shifts the bits through the pending
// register and packs the decoded characters of the item into a queue entry.
// ---------------------------------------------------------------------------
module c2b_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_code,
   input  logic                has_char,
   input  logic                line_end,
   output logic                q_push,
   output c2b_pkg::entry_type  q_entry
);

   logic [6:0]       pend_bits_ff, pend_bits_in;
   logic [2:0]       pend_cnt_ff, pend_cnt_in;

   c2b_pkg::sym_type sym;
   logic [6:0]       pb;
   logic [2:0]       pc;
   logic [7:0]       word;
   logic [3:0]       len;
   logic [6:0]       hit_ch;
   logic [1:0]       nres;
   logic [6:0]       ch0, ch1;

   always_comb begin
      sym    = c2b_pkg::symbol_of(char_code);
      pb     = pend_bits_ff;
      pc     = pend_cnt_ff;
      word   = '0;
      len    = '0;
      hit_ch = '0;
      nres   = '0;
      ch0    = '0;
      ch1    = '0;
      if (has_char && sym.hit) begin
         // five bit steps, most significant symbol bit first
         for (int i = 0; i < 5; i++) begin
            word   = {pb, sym.code[3'(4 - i)]};
            len    = {1'b0, pc} + 4'd1;
            hit_ch = c2b_pkg::lookup(len, word);
            if (hit_ch != 7'd0) begin
               if (nres == 2'd0) begin
                  ch0 = hit_ch;
               end else if (nres == 2'd1) begin
                  ch1 = hit_ch;
               end
               if (nres != 2'd2) begin
                  nres = nres + 2'd1;
               end
               pb = '0;
               pc = '0;
            end else if (len >= 4'd8) begin
               // drop an unmatched full byte
               pb = '0;
               pc = '0;
            end else begin
               pb = word[6:0];
               pc = len[2:0];
            end
         end
      end
      pend_bits_in = line_end ? 7'd0 : pb;
      pend_cnt_in  = line_end ? 3'd0 : pc;
   end

   always_comb begin
      q_push = accept && ((nres != 2'd0) || line_end);
      q_entry.two = (nres == 2'd2);
      if (nres == 2'd0) begin
         q_entry.first.out_char     = '0;
         q_entry.first.out_valid    = 1'b0;
         q_entry.first.out_line_end = 1'b1;
      end else begin
         q_entry.first.out_char     = ch0;
         q_entry.first.out_valid    = 1'b1;
         q_entry.first.out_line_end = line_end && (nres == 2'd1);
      end
      q_entry.second.out_char     = ch1;
      q_entry.second.out_valid    = 1'b1;
      q_entry.second.out_line_end = line_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else if (accept) begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

endmodule

// ----- hw/rtl/c2b_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2b_queue
// Short entry queue between the decode front and the result back end.
// ---------------------------------------------------------------------------
module c2b_queue #(
   parameter int DEPTH = c2b_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  c2b_pkg::entry_type    wr_data,
   input  logic                  rd_en,
   output c2b_pkg::entry_type    rd_data,
   output c2b_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   c2b_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_pop       = rd_en && !status.empty;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({wr_en, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

// ----- hw/rtl/c2b_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2b_back
// Splits queue entries into single results and holds them in the output
// register until the consumer takes them.
// ---------------------------------------------------------------------------
module c2b_back (
   input  logic                  clock,
   input  logic                  reset,
   input  c2b_pkg::q_status_type q_status,
   input  c2b_pkg::entry_type    q_head,
   output logic                  q_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output c2b_pkg::rsp_type      rsp
);

   c2b_pkg::rsp_type rsp_ff, rsp_in;
   logic             full_ff;
   logic             idx_ff, idx_in;
   logic             load;
   logic             take;

   // the output register frees up when empty or when its result is taken
   assign load      = !full_ff || rsp_pop;
   assign take      = load && !q_status.empty;
   assign q_pop     = take && (idx_ff || !q_head.two);
   assign rsp_empty = !full_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      rsp_in = idx_ff ? q_head.second : q_head.first;
      idx_in = idx_ff;
      if (take) begin
         idx_in = !q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            full_ff <= !q_status.empty;
         end
      end
   end

endmodule

// ----- hw/rtl/char_to_bits_prefix_code_decoder_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_to_bits_prefix_code_decoder_unit
// Character to 5-bit symbol to prefix-code decoder, queue in and queue out.
// ---------------------------------------------------------------------------
// One character is accepted every cycle while req_full is low. Its five
// symbol bits are shifted through the pending register and matched against
// the codeword table in the cycle of acceptance; the zero, one or two decoded
// characters, together with the line end mark, go into a QUEUE_DEPTH-entry
// queue. The back end hands out one result per cycle from its output
// register while the consumer pops it; a result passes through the queue
// and then the output register, and an item that decodes two characters
// gives two results one after the other;
// the queue absorbs those bursts. Items that decode nothing and carry no
// line end produce no result and take no queue slot. A line end with no
// decoded character gives one result with rsp_out_valid low.
// ---------------------------------------------------------------------------
`include "char_to_bits_prefix_code_decoder_unit_defines.svh"

module char_to_bits_prefix_code_decoder_unit #(
   parameter int QUEUE_DEPTH = c2b_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_has_char,
   input  logic       req_line_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_out_valid,
   output logic       rsp_out_line_end
);

   c2b_pkg::entry_type    q_wr_data, q_head;
   c2b_pkg::q_status_type q_status;
   c2b_pkg::rsp_type      rsp;
   logic                  accept;
   logic                  q_wr_en;
   logic                  q_rd_en;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   c2b_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .has_char  (req_has_char),
      .line_end  (req_line_end),
      .q_push    (q_wr_en),
      .q_entry   (q_wr_data)
   );

   c2b_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_data (q_head),
      .status  (q_status)
   );

   c2b_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_rd_en),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_out_char     = rsp.out_char;
   assign rsp_out_valid    = rsp.out_valid;
   assign rsp_out_line_end = rsp.out_line_end;

   `C2B_ASSERT_IMP(a_no_write_when_full, q_wr_en, !q_status.full, "queue written while full")
   `C2B_ASSERT_IMP(a_no_read_when_empty, q_rd_en, !q_status.empty, "queue read while empty")
   `C2B_ASSERT_IMP(a_blank_result_ends_line, !rsp_empty && !rsp_out_valid, (rsp_out_char == 7'd0) && rsp_out_line_end, "blank result not a line end")
   `C2B_ASSERT_NXT(a_result_follows_entry, !q_status.empty && !rsp_empty && rsp_pop, !rsp_empty, "output drained with entries waiting")

endmodule
